/* rtl/core/efd_pkg.sv */
// shared constants and types of the elias-fano decoder
// no dependencies; imported by elias_fano_decoder
package efd_pkg;

    // default size of the low-part byte store
    localparam int unsigned EFD_LOW_STORE_BYTES = 65536;

    // input operation codes (carried on the input tuser)
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_HIGH = 1'b1;

    // configuration register indexes
    localparam logic REG_LOW_WIDTH   = 1'b0;
    localparam logic REG_VALUE_COUNT = 1'b1;

    // result status codes (carried on the output tuser)
    typedef enum logic [1:0] {
        STATUS_VALUE     = 2'd0,
        STATUS_LOW_RANGE = 2'd1,
        STATUS_COUNT_BAD = 2'd2,
        STATUS_END_OK    = 2'd3
    } status_t;

endpackage

/* rtl/core/efd_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module efd_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/elias_fano_decoder.sv */
// elias-fano sequence decoder, top level
// depends on efd_pkg and efd_ram
//
// Decodes a sorted integer sequence held in Elias-Fano form. Load transactions
// (tuser = 0) append one byte each to the packed array of low parts; high
// transactions (tuser = 1) supply the high bitmap one byte at a time, tlast
// marking the final byte. For each set bit of a high byte, lowest bit first,
// one value is emitted: (bit position - values found so far) << low_width,
// ORed with the low part of that value, unpacked little-endian from the store.
// Decoding stops once value_count values were found. A low part starting at
// or past the loaded bytes, or needing a ninth byte that is not loaded, gives
// one result with status 1 and ends that high byte. After the final high byte
// one end result follows (status 3 when the count matches, else 2) and the
// block is ready for a new sequence. The low store is a single memory of
// 64-bit rows (LOW_STORE_BYTES/8 rows); a row buffer collects the bytes of the
// current row and the whole row is written on each load. A high byte is
// accepted, then each decoded value goes through bit search and multiply, two
// row reads through the one read port of the store, extraction and output; a
// closing bit search follows, then the end result when tlast is set. A result
// that waits on m_axis_tready holds the engine. The engine takes one high
// byte at a time; a finished result waits in the output register while the
// next transaction is accepted.
// Configuration is to be written through cfg_* only while no transaction is
// in work; the block itself does not enforce this.
module elias_fano_decoder
    import efd_pkg::*;
#(
    parameter int unsigned LOW_STORE_BYTES = EFD_LOW_STORE_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,      // 0 low_width, 1 value_count
    input  logic [31:0] cfg_data,       // low_width in [5:0], value_count in [31:0]
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] op
    input  logic        s_axis_tlast,   // final_high
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] value
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast    // last
);

    localparam int unsigned ROWS = (LOW_STORE_BYTES + 7) / 8;
    localparam int unsigned RAW  = $clog2(ROWS);
    localparam int unsigned LW   = $clog2(LOW_STORE_BYTES + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SCAN = 8'b0000_0010,
        S_ADDR = 8'b0000_0100,
        S_RD1  = 8'b0000_1000,
        S_RD2  = 8'b0001_0000,
        S_EXTR = 8'b0010_0000,
        S_EMIT = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } state_t;

    // control state
    state_t      state_reg, state_next;
    logic [5:0]  low_width_reg, low_width_next;
    logic [31:0] value_count_reg, value_count_next;
    logic [LW-1:0] loaded_reg, loaded_next;
    logic [31:0] found_reg, found_next;
    logic [31:0] hbi_reg, hbi_next;
    logic        m_valid_reg, m_valid_next;

    // datapath
    logic [7:0]  byte_reg, byte_next;
    logic        fin_reg, fin_next;
    logic [2:0]  bit_reg, bit_next;
    logic [37:0] bitpos_reg, bitpos_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] win_lo_reg, win_lo_next;
    logic [63:0] win_hi_reg, win_hi_next;
    logic [63:0] low_reg, low_next;
    logic [63:0] high_reg, high_next;
    logic        err_reg, err_next;
    logic [63:0] m_value_reg, m_value_next;
    status_t     m_status_reg, m_status_next;
    logic        m_last_reg, m_last_next;

    // memory port
    logic           ram_we;
    logic           ram_re;
    logic [RAW-1:0] ram_raddr;
    logic [63:0]    ram_rdata;

    // helpers
    logic          out_free;
    logic [7:0]    rest;
    logic          more;
    logic [37:0]   prod;
    logic [35:0]   diff;
    logic [127:0]  window_m;
    logic [127:0]  shifted;
    logic [63:0]   wmask;
    logic [34:0]   first;
    logic          err_a;
    logic          err_b;
    logic          ninth_need;

    function automatic logic [2:0] lowest_set(input logic [7:0] b);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (b[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    efd_ram #(
        .WIDTH (64),
        .DEPTH (ROWS)
    ) u_low_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (loaded_reg[RAW+2:3]),
        .wdata (acc_next),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_value_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tlast  = m_last_reg;

    // result register may take a new result this cycle
    assign out_free = !m_valid_reg || m_axis_tready;

    // remaining bits of the high byte and whether another value follows
    assign rest = byte_reg & (byte_reg - 8'd1);
    assign more = (rest != 8'd0) && ((33'(found_reg) + 33'd1) < 33'(value_count_reg));

    // bit address of the low part of value found_reg
    assign prod = {6'd0, found_reg} * {32'd0, low_width_reg};

    // first row of the window; the next row is read in the state after
    assign ram_raddr = (state_reg == S_RD1) ? (bitpos_reg[RAW+5:6] + RAW'(1))
                                            : bitpos_reg[RAW+5:6];

    // low part extraction over the two-row window
    always_comb
    begin
        diff = 36'(loaded_reg) - 36'({bitpos_reg[37:6], 3'b000});
        for (int j = 0; j < 16; j++)
        begin
            // bytes at or past the loaded count read as zero
            if (!diff[35] && (diff[34:0] > 35'(j)))
            begin
                window_m[j*8 +: 8] = (j < 8) ? win_lo_reg[(j%8)*8 +: 8]
                                             : win_hi_reg[(j%8)*8 +: 8];
            end
            else
            begin
                window_m[j*8 +: 8] = 8'h00;
            end
        end
        shifted    = window_m >> bitpos_reg[5:0];
        wmask      = (64'd1 << low_width_reg) - 64'd1;
        first      = bitpos_reg[37:3];
        err_a      = first >= 35'(loaded_reg);
        ninth_need = (7'd64 - 7'(bitpos_reg[2:0])) < 7'(low_width_reg);
        err_b      = ninth_need && ((36'(first) + 36'd8) >= 36'(loaded_reg));
    end

    always_comb
    begin
        state_next       = state_reg;
        low_width_next   = low_width_reg;
        value_count_next = value_count_reg;
        loaded_next      = loaded_reg;
        found_next       = found_reg;
        hbi_next         = hbi_reg;
        byte_next        = byte_reg;
        fin_next         = fin_reg;
        bit_next         = bit_reg;
        bitpos_next      = bitpos_reg;
        acc_next         = acc_reg;
        win_lo_next      = win_lo_reg;
        win_hi_next      = win_hi_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        err_next         = err_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        m_value_next     = m_value_reg;
        m_status_next    = m_status_reg;
        m_last_next      = m_last_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;

        if (cfg_valid)
        begin
            if (cfg_index == REG_LOW_WIDTH)
            begin
                low_width_next = cfg_data[5:0];
            end
            else
            begin
                value_count_next = cfg_data;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == OP_LOAD)
                    begin
                        // loads past the end of the store are dropped
                        if (loaded_reg < LW'(LOW_STORE_BYTES))
                        begin
                            acc_next = (loaded_reg[2:0] == 3'd0) ? 64'd0 : acc_reg;
                            acc_next[{loaded_reg[2:0], 3'b000} +: 8] = s_axis_tdata;
                            ram_we      = 1'b1;
                            loaded_next = loaded_reg + LW'(1);
                        end
                    end
                    else
                    begin
                        byte_next  = s_axis_tdata;
                        fin_next   = s_axis_tlast;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if ((byte_reg != 8'd0) && (found_reg < value_count_reg))
                begin
                    bit_next    = lowest_set(byte_reg);
                    bitpos_next = prod;
                    state_next  = S_ADDR;
                end
                else
                begin
                    hbi_next   = hbi_reg + 32'd1;
                    state_next = fin_reg ? S_FIN : S_IDLE;
                end
            end
            S_ADDR:
            begin
                ram_re     = 1'b1;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                ram_re      = 1'b1;
                win_lo_next = ram_rdata;
                state_next  = S_RD2;
            end
            S_RD2:
            begin
                win_hi_next = ram_rdata;
                state_next  = S_EXTR;
            end
            S_EXTR:
            begin
                low_next   = shifted[63:0] & wmask;
                high_next  = 64'({hbi_reg, bit_reg}) - 64'(found_reg);
                err_next   = (low_width_reg != 6'd0) && (err_a || err_b);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    if (err_reg)
                    begin
                        // the rest of this high byte is dropped
                        m_value_next  = 64'd0;
                        m_status_next = STATUS_LOW_RANGE;
                        m_last_next   = !fin_reg;
                        byte_next     = 8'd0;
                    end
                    else
                    begin
                        m_value_next  = (high_reg << low_width_reg) | low_reg;
                        m_status_next = STATUS_VALUE;
                        m_last_next   = !more && !fin_reg;
                        found_next    = found_reg + 32'd1;
                        byte_next     = rest;
                    end
                    state_next = S_SCAN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_value_next  = 64'd0;
                    m_status_next = (found_reg == value_count_reg) ? STATUS_END_OK
                                                                   : STATUS_COUNT_BAD;
                    m_last_next   = 1'b1;
                    loaded_next   = '0;
                    found_next    = 32'd0;
                    hbi_next      = 32'd0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            low_width_reg   <= 6'd0;
            value_count_reg <= 32'd0;
            loaded_reg      <= '0;
            found_reg       <= 32'd0;
            hbi_reg         <= 32'd0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            low_width_reg   <= low_width_next;
            value_count_reg <= value_count_next;
            loaded_reg      <= loaded_next;
            found_reg       <= found_next;
            hbi_reg         <= hbi_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        fin_reg      <= fin_next;
        bit_reg      <= bit_next;
        bitpos_reg   <= bitpos_next;
        acc_reg      <= acc_next;
        win_lo_reg   <= win_lo_next;
        win_hi_reg   <= win_hi_next;
        low_reg      <= low_next;
        high_reg     <= high_next;
        err_reg      <= err_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    // store is only written while the engine is idle
    a_store_port: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re)
        else $error("low store read and written in the same cycle");

    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= LW'(LOW_STORE_BYTES))
        else $error("loaded byte count beyond store size");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && out_free) |=> m_valid_reg)
        else $error("result not presented after emit");

    a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && out_free) |=>
            ((loaded_reg == '0) && (found_reg == 32'd0) && (hbi_reg == 32'd0)))
        else $error("sequence state not cleared after end result");

endmodule

/* test/tb.sv */
// self-checking testbench for elias_fano_decoder: directed, random and stress sequences
// depends on efd_pkg and the decoder rtl; keeps its own software copy of the decoder state
module tb
    import efd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_BYTES   = EFD_LOW_STORE_BYTES;
    localparam int unsigned RANDOM_ITEMS  = 500;
    localparam int unsigned SETTLE_CYCLES = 64;        // room for the longest high byte to finish
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;

    typedef struct packed {
        logic [63:0] value;
        status_t     status;
        logic        last;
    } decoded_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_LOW_WIDTH;
    logic [31:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic        s_axis_tuser = OP_LOAD; // [0] op
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // [63:0] value
    logic [1:0]  m_axis_tuser;        // [1:0] status
    logic        m_axis_tlast;

    // decoder state as the testbench sees it
    logic [7:0]  store_copy [STORE_BYTES];
    int unsigned loaded_bytes = 0;
    logic [31:0] values_found = '0;
    logic [31:0] high_index = '0;
    logic [5:0]  cur_low_width = '0;
    logic [31:0] cur_value_count = '0;

    decoded_t    pending_results [$];
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;

    // idling control
    bit          no_idle = 1'b0;
    bit          hold_start = 1'b0;
    bit          hold_seen = 1'b0;
    int unsigned hold_left = 0;

    elias_fano_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // low part of value idx, unpacked little-endian; 0 when the read is out of range
    function automatic bit unpack_low(input logic [31:0] idx, output logic [63:0] low_part);
        logic [63:0] bitpos;
        logic [63:0] first;
        logic [63:0] word;
        int unsigned sh;
        int unsigned room;
        int unsigned avail;
        int unsigned b;
        low_part = '0;
        if (cur_low_width == 6'd0)
            return 1'b1;
        bitpos = 64'(idx) * 64'(cur_low_width);
        first  = bitpos >> 3;
        sh     = 32'(bitpos[2:0]);
        if (first >= 64'(loaded_bytes))
            return 1'b0;
        avail = (64'(loaded_bytes) - first > 64'd8) ? 8 : int'(64'(loaded_bytes) - first);
        word = '0;
        for (b = 0; b < avail; b++)
            word |= 64'(store_copy[first + b]) << (8 * b);
        word = word >> sh;
        room = 64 - sh;
        if (room < cur_low_width)
        begin
            // part spills into a ninth byte that must already be loaded
            if (first + 64'd8 >= 64'(loaded_bytes))
                return 1'b0;
            word |= 64'(store_copy[first + 8]) << room;
        end
        low_part = word & ((64'd1 << cur_low_width) - 64'd1);
        return 1'b1;
    endfunction

    // advance the decoder state by one accepted item and queue the results it causes
    task automatic decode_item(input logic op, input logic [7:0] data, input logic fin);
        logic [7:0]  bits;
        logic [63:0] pos;
        logic [63:0] low_part;
        decoded_t    batch [$];
        decoded_t    r;
        int          bitn;
        int          k;
        if (op == OP_LOAD)
        begin
            // loads past the end of the store are dropped
            if (loaded_bytes < STORE_BYTES)
            begin
                store_copy[loaded_bytes] = data;
                loaded_bytes++;
            end
            return;
        end
        bits = data;
        bitn = 0;
        while (bits != 8'h00 && values_found < cur_value_count)
        begin
            for (k = 7; k >= 0; k--)
                if (bits[k])
                    bitn = k;
            pos = 64'(high_index) * 64'd8 + 64'(bitn);
            r.last = 1'b0;
            if (!unpack_low(values_found, low_part))
            begin
                // flag once, drop the rest of this byte
                r.value  = '0;
                r.status = STATUS_LOW_RANGE;
                batch.insert(batch.size(), r);
                break;
            end
            r.value  = ((pos - 64'(values_found)) << cur_low_width) | low_part;
            r.status = STATUS_VALUE;
            batch.insert(batch.size(), r);
            values_found++;
            bits = bits & (bits - 8'h01);
        end
        high_index++;
        if (fin)
        begin
            r.value  = '0;
            r.status = (values_found == cur_value_count) ? STATUS_END_OK : STATUS_COUNT_BAD;
            r.last   = 1'b0;
            batch.insert(batch.size(), r);
            loaded_bytes = 0;
            values_found = '0;
            high_index   = '0;
        end
        for (k = 0; k < batch.size(); k++)
        begin
            r = batch[k];
            r.last = (k == batch.size() - 1);
            pending_results.insert(pending_results.size(), r);
        end
    endtask

    // offer one item, with random idle cycles in front unless idling is off
    task automatic send_item(input logic op, input logic [7:0] data, input logic fin);
        bit idle_now;
        idle_now = !no_idle && ($urandom_range(99, 0) < 31);
        if (idle_now)
        begin
            s_axis_tvalid <= 1'b0;
            while (idle_now)
            begin
                @(posedge clk);
                idle_now = ($urandom_range(99, 0) < 31);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_item(op, data, fin);
        items_sent++;
    endtask

    // stop offering, let every expected result arrive, then let the engine settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // writes both registers back to back; upper data bits of low_width are noise
    task automatic set_config(input logic [5:0] width, input logic [31:0] count);
        cfg_valid <= 1'b1;
        cfg_index <= REG_LOW_WIDTH;
        cfg_data  <= ($urandom() & 32'hFFFF_FFC0) | 32'(width);
        do
            @(posedge clk);
        while (!cfg_ready);
        cur_low_width = width;
        cfg_index <= REG_VALUE_COUNT;
        cfg_data  <= count;
        do
            @(posedge clk);
        while (!cfg_ready);
        cur_value_count = count;
        cfg_valid <= 1'b0;
    endtask

    // receiver: random ready, or a counted hold-off when the test asks for one
    always @(posedge clk)
    begin
        if (hold_start != hold_seen)
        begin
            hold_seen = hold_start;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= no_idle || ($urandom_range(99, 0) >= 31);
    end

    // compare every result transaction with the oldest expectation
    always @(posedge clk)
    begin : check_results
        decoded_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result value=%h status=%0d last=%b",
                                          m_axis_tdata, m_axis_tuser, m_axis_tlast));
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.value || m_axis_tuser !== want.status ||
                    m_axis_tlast !== want.last)
                    report_mismatch($sformatf(
                        "got value=%h status=%0d last=%b, want value=%h status=%0d last=%b",
                        m_axis_tdata, m_axis_tuser, m_axis_tlast,
                        want.value, want.status, want.last));
            end
        end
    end

    // reset registers, zero width, final mark on a load, count reached, empty byte
    task automatic test_zero_width();
        send_item(OP_HIGH, 8'hFF, 1'b1);       // count 0 after reset: only the end result
        wait_idle();
        set_config(6'd0, 32'd3);
        send_item(OP_LOAD, 8'hFF, 1'b1);       // final mark ignored on a load
        send_item(OP_HIGH, 8'h00, 1'b0);
        send_item(OP_HIGH, 8'hFF, 1'b0);       // three values, then count reached
        send_item(OP_HIGH, 8'h80, 1'b1);
    endtask

    // first byte of a low part not loaded, loads between high bytes, count mismatch
    task automatic test_low_range();
        wait_idle();
        set_config(6'd8, 32'd4);
        send_item(OP_LOAD, 8'hA5, 1'b0);
        send_item(OP_HIGH, 8'h03, 1'b0);
        send_item(OP_LOAD, 8'h3C, 1'b0);
        send_item(OP_HIGH, 8'h01, 1'b1);
    endtask

    // low parts at the end of the loaded bytes: partial read, then a missing ninth byte
    task automatic test_store_edge();
        int k;
        wait_idle();
        set_config(6'd12, 32'd2);
        send_item(OP_LOAD, 8'($urandom), 1'b0);
        send_item(OP_LOAD, 8'($urandom), 1'b0);
        send_item(OP_HIGH, 8'h05, 1'b1);
        wait_idle();
        set_config(6'd63, 32'd2);
        send_item(OP_LOAD, 8'hFF, 1'b0);
        send_item(OP_LOAD, 8'h00, 1'b0);
        for (k = 0; k < 6; k++)
            send_item(OP_LOAD, 8'($urandom), 1'b0);
        send_item(OP_HIGH, 8'h11, 1'b1);
    endtask

    // one coded sequence with random content; broken ones cut the low array,
    // scramble bitmap bytes or leave the sequence open
    task automatic run_sequence(input bit broken);
        logic [5:0]  width;
        logic [31:0] count;
        logic [7:0]  bitmap [$];
        int unsigned n;
        int unsigned nbytes;
        int unsigned split;
        int unsigned hi;
        int unsigned pos;
        int          k;
        bit          close;
        case ($urandom_range(7, 0))
            0:       width = 6'd0;
            1:       width = 6'd63;
            2:       width = 6'($urandom_range(62, 17));
            default: width = 6'($urandom_range(16, 1));
        endcase
        n = $urandom_range(12, 0);
        case ($urandom_range(19, 0))
            0:       count = n + 1;
            1:       count = (n > 0) ? n - 1 : 0;
            2:       count = 32'hFFFF_FFFF;
            3:       count = 32'd0;
            default: count = n;
        endcase
        nbytes = (n * width + 7) / 8;
        if (broken && $urandom_range(1, 0) == 1)
            nbytes = $urandom_range(nbytes, 0);
        // bit of value k sits at its high part plus k
        hi = 0;
        for (k = 0; k < n; k++)
        begin
            hi += ($urandom_range(3, 0) == 0) ? $urandom_range(20, 0) : $urandom_range(2, 0);
            pos = hi + k;
            while (bitmap.size() <= pos / 8)
                bitmap.insert(bitmap.size(), 8'h00);
            bitmap[pos / 8] = bitmap[pos / 8] | (8'h01 << (pos % 8));
        end
        if (bitmap.size() == 0 || $urandom_range(3, 0) == 0)
            bitmap.insert(bitmap.size(), 8'h00);
        if (broken)
            for (k = 0; k < bitmap.size(); k++)
                if ($urandom_range(2, 0) == 0)
                    bitmap[k] = 8'($urandom);
        split = (broken || $urandom_range(6, 0) == 0) ? $urandom_range(nbytes, 0) : nbytes;
        close = !(broken && $urandom_range(3, 0) == 0);
        wait_idle();
        set_config(width, count);
        for (k = 0; k < split; k++)
            send_item(OP_LOAD, 8'($urandom), 1'($urandom));
        for (k = 0; k < bitmap.size(); k++)
        begin
            send_item(OP_HIGH, bitmap[k], close && (k == bitmap.size() - 1));
            // rest of the low array arrives after the first high byte
            if (k == 0)
                for (int j = split; j < nbytes; j++)
                    send_item(OP_LOAD, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_random_sequences();
        int unsigned start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            // a stretch with no idling on either side
            no_idle = (items_sent - start >= 150) && (items_sent - start < 260);
            run_sequence($urandom_range(3, 0) == 0);
        end
        no_idle = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        int k;
        wait_idle();
        set_config(6'd4, 32'd40);
        send_item(OP_HIGH, 8'h00, 1'b1);       // close whatever sequence is open
        hold_start = !hold_start;
        for (k = 0; k < 20; k++)
            send_item(OP_LOAD, 8'($urandom), 1'b0);
        for (k = 0; k < 5; k++)
            send_item(OP_HIGH, 8'hFF, 1'b0);
        send_item(OP_HIGH, 8'h00, 1'b1);
        // sender pauses until every result is out
        wait_idle();
    endtask

    // low array shorter than the bitmap asks for: decode up to the last whole low part
    task automatic test_array_end();
        int k;
        wait_idle();
        set_config(6'd63, 32'hFFFF_FFFF);
        send_item(OP_HIGH, 8'h00, 1'b1);       // close whatever sequence is open
        for (k = 0; k < 40; k++)
            send_item(OP_LOAD, 8'($urandom), 1'($urandom));
        // five low parts fit in 40 bytes, the sixth needs a ninth byte not loaded
        send_item(OP_HIGH, 8'hFF, 1'b0);
        send_item(OP_HIGH, 8'hFF, 1'b0);
        send_item(OP_HIGH, 8'h00, 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_zero_width();
        test_low_range();
        test_store_edge();
        test_random_sequences();
        test_backpressure();
        test_array_end();
        wait_idle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* elias_fano_decoder.f */
rtl/core/efd_pkg.sv
rtl/core/efd_ram.sv
rtl/core/elias_fano_decoder.sv
test/tb.sv
